// ===== sv/sctc_pkg.sv =====
// Shared types and constants for the sector to CHS translator with track cache.
// Used by sctc_div, sctc_dp, sctc_ctrl and sector_to_chs_track_cache.
package sctc_pkg;

  localparam int SEC_W      = 24;
  localparam int GEO_W      = 8;
  localparam int FIRST_W    = 25;
  localparam int COUNT_W    = 6;
  localparam int SLOT_W     = 6;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int TRIES_W    = 3;
  localparam int DIV_CNT_W  = $clog2(SEC_W);

  localparam logic [SEC_W-1:0]   TRACK_SECTORS_MAX = SEC_W'(21);
  localparam logic [GEO_W-1:0]   TRACK_READ_MIN    = GEO_W'(7);
  localparam logic [TRIES_W-1:0] READ_TRIES        = TRIES_W'(5);

  localparam logic [GEO_W-1:0] DEFAULT_SPT   = GEO_W'(7);
  localparam logic [GEO_W-1:0] DEFAULT_HEADS = GEO_W'(2);
  localparam logic [GEO_W-1:0] DEFAULT_DRIVE = GEO_W'(0);

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SPT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HEADS = CFG_IDX_W'(2);

  localparam logic [KIND_W-1:0] KIND_TRACK  = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_SECTOR = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_DONE   = KIND_W'(2);
  localparam logic [KIND_W-1:0] KIND_FAIL   = KIND_W'(3);

  typedef struct packed {
    logic              load_req;
    logic              pass;
    logic              div1_start;
    logic              div1_store;
    logic              div2_start;
    logic              div2_store;
    logic              mul;
    logic              lt;
    logic              cache_set;
    logic              bad_set;
    logic              cache_clr;
    logic              out_load;
    logic [KIND_W-1:0] out_kind;
    logic              out_slot;
  } sctc_cmd_t;

  typedef struct packed {
    logic geo_zero;
    logic div_done;
    logic track_cond;
    logic hit;
    logic out_free;
  } sctc_stat_t;

endpackage

// ===== sv/sector_to_chs_track_cache.sv =====
// Sector to CHS translator with a one-track read cache and retried sector reads.
// A translated request runs two serial divides before its result is loaded.
// Untranslated requests and read status transfers run no divide; any item may wait for a free output register.
// Throughput: one item at a time; in_ready_o is high only while the controller is idle.
// Reset (rst_ni low, asynchronous): geometry 7 sectors, 2 heads, drive 0, no cache, no bad track.
// Depends on sctc_pkg, sctc_ctrl, sctc_dp and sctc_div.
module sector_to_chs_track_cache (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sctc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sctc_pkg::GEO_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [sctc_pkg::SEC_W-1:0]     sector_number_i,
  input  logic                           read_ok_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sctc_pkg::KIND_W-1:0]    kind_o,
  output logic [sctc_pkg::GEO_W-1:0]     drive_o,
  output logic [sctc_pkg::SEC_W-1:0]     cylinder_o,
  output logic [sctc_pkg::GEO_W-1:0]     head_o,
  output logic [sctc_pkg::FIRST_W-1:0]   first_sector_o,
  output logic [sctc_pkg::COUNT_W-1:0]   sector_count_o,
  output logic [sctc_pkg::SLOT_W-1:0]    buffer_slot_o
);

  sctc_pkg::sctc_cmd_t  cmd;
  sctc_pkg::sctc_stat_t stat;

  sctc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .read_ok_i  (read_ok_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sctc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .sector_number_i (sector_number_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .drive_o         (drive_o),
    .cylinder_o      (cylinder_o),
    .head_o          (head_o),
    .first_sector_o  (first_sector_o),
    .sector_count_o  (sector_count_o),
    .buffer_slot_o   (buffer_slot_o)
  );

endmodule

// ===== sv/sctc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sctc_pkg for widths.
module sctc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sctc_pkg::SEC_W-1:0] dividend_i,
  input  logic [sctc_pkg::GEO_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [sctc_pkg::SEC_W-1:0] quot_o,
  output logic [sctc_pkg::GEO_W-1:0] rem_o
);

  localparam logic [sctc_pkg::DIV_CNT_W-1:0] CNT_LAST =
    sctc_pkg::DIV_CNT_W'(sctc_pkg::SEC_W - 1);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [sctc_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [sctc_pkg::SEC_W-1:0]     quot_q, quot_d;
  logic [sctc_pkg::GEO_W-1:0]     rem_q, rem_d;
  logic [sctc_pkg::GEO_W-1:0]     div_q, div_d;
  logic [sctc_pkg::GEO_W:0]       shifted;
  logic [sctc_pkg::GEO_W:0]       diff;
  logic                           fits;

  assign shifted = {rem_q, quot_q[sctc_pkg::SEC_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (busy_q) begin
      quot_d = {quot_q[sctc_pkg::SEC_W-2:0], fits};
      rem_d  = fits ? diff[sctc_pkg::GEO_W-1:0] : shifted[sctc_pkg::GEO_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/sctc_dp.sv =====
// Datapath: geometry registers, translation, track cache, bad-track mark and result register.
// Depends on sctc_pkg and instantiates sctc_div.
module sctc_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sctc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sctc_pkg::GEO_W-1:0]     cfg_data_i,
  input  logic [sctc_pkg::SEC_W-1:0]     sector_number_i,
  input  sctc_pkg::sctc_cmd_t            cmd_i,
  output sctc_pkg::sctc_stat_t           stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sctc_pkg::KIND_W-1:0]    kind_o,
  output logic [sctc_pkg::GEO_W-1:0]     drive_o,
  output logic [sctc_pkg::SEC_W-1:0]     cylinder_o,
  output logic [sctc_pkg::GEO_W-1:0]     head_o,
  output logic [sctc_pkg::FIRST_W-1:0]   first_sector_o,
  output logic [sctc_pkg::COUNT_W-1:0]   sector_count_o,
  output logic [sctc_pkg::SLOT_W-1:0]    buffer_slot_o
);

  localparam int PROD_W = sctc_pkg::SEC_W + sctc_pkg::GEO_W;

  logic [sctc_pkg::GEO_W-1:0]   drive_q, spt_q, heads_q;
  logic                         cache_v_q, bad_v_q;
  logic [sctc_pkg::SEC_W-1:0]   cache_trk_q, bad_trk_q;
  logic [sctc_pkg::SEC_W-1:0]   sec_q, quot1_q;
  logic [sctc_pkg::SEC_W-1:0]   cur_sec_q, cur_cyl_q;
  logic [sctc_pkg::GEO_W-1:0]   cur_head_q;
  logic [sctc_pkg::SEC_W-1:0]   prod_q, lt_q;
  logic [PROD_W-1:0]            prod_full;

  logic                         out_valid_q;
  logic [sctc_pkg::KIND_W-1:0]  kind_q;
  logic [sctc_pkg::GEO_W-1:0]   drv_q, head_q;
  logic [sctc_pkg::SEC_W-1:0]   cyl_q;
  logic [sctc_pkg::FIRST_W-1:0] first_q;
  logic [sctc_pkg::COUNT_W-1:0] count_q;
  logic [sctc_pkg::SLOT_W-1:0]  slot_q;

  logic                         div_start, div_done;
  logic [sctc_pkg::SEC_W-1:0]   div_dividend, div_quot;
  logic [sctc_pkg::GEO_W-1:0]   div_divisor, div_rem;
  logic                         cache_hit_trk, bad_hit_trk;

  assign div_start    = cmd_i.div1_start | cmd_i.div2_start;
  assign div_dividend = cmd_i.div2_start ? quot1_q : sec_q;
  assign div_divisor  = cmd_i.div2_start ? heads_q : spt_q;

  sctc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign prod_full     = cur_cyl_q * heads_q;
  assign cache_hit_trk = cache_v_q && (cache_trk_q == lt_q);
  assign bad_hit_trk   = bad_v_q && (bad_trk_q == lt_q);

  always_comb begin
    stat_o.geo_zero   = (spt_q == '0) || (heads_q == '0);
    stat_o.div_done   = div_done;
    stat_o.track_cond = (spt_q > sctc_pkg::TRACK_READ_MIN) &&
                        ({{(sctc_pkg::SEC_W-sctc_pkg::GEO_W){1'b0}}, spt_q} <=
                         sctc_pkg::TRACK_SECTORS_MAX) &&
                        !cache_hit_trk && !bad_hit_trk;
    stat_o.hit        = cache_hit_trk && (cur_sec_q < sctc_pkg::TRACK_SECTORS_MAX);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Configuration, cache and bad-track state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q   <= sctc_pkg::DEFAULT_DRIVE;
      spt_q     <= sctc_pkg::DEFAULT_SPT;
      heads_q   <= sctc_pkg::DEFAULT_HEADS;
      cache_v_q <= 1'b0;
      bad_v_q   <= 1'b0;
    end else begin
      if (cmd_i.load_req && (sector_number_i == '0)) begin
        spt_q   <= sctc_pkg::DEFAULT_SPT;
        heads_q <= sctc_pkg::DEFAULT_HEADS;
        bad_v_q <= 1'b0;
      end else if (cfg_we_i) begin
        case (cfg_idx_i)
          sctc_pkg::REG_DRIVE: drive_q <= cfg_data_i;
          sctc_pkg::REG_SPT:   spt_q   <= cfg_data_i;
          sctc_pkg::REG_HEADS: heads_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.cache_set) begin
        cache_v_q <= 1'b1;
      end else if (cmd_i.cache_clr) begin
        cache_v_q <= 1'b0;
      end
      if (cmd_i.bad_set) begin
        bad_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cache_set) begin
      cache_trk_q <= lt_q;
    end
    if (cmd_i.bad_set) begin
      bad_trk_q <= lt_q;
    end
    if (cmd_i.load_req) begin
      sec_q <= sector_number_i;
    end
    if (cmd_i.pass) begin
      cur_sec_q  <= sec_q;
      cur_head_q <= '0;
      cur_cyl_q  <= '0;
    end
    if (cmd_i.div1_store) begin
      cur_sec_q <= {{(sctc_pkg::SEC_W-sctc_pkg::GEO_W){1'b0}}, div_rem};
      quot1_q   <= div_quot;
    end
    if (cmd_i.div2_store) begin
      cur_head_q <= div_rem;
      cur_cyl_q  <= div_quot;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[sctc_pkg::SEC_W-1:0];
    end
    if (cmd_i.lt) begin
      lt_q <= prod_q + {{(sctc_pkg::SEC_W-sctc_pkg::GEO_W){1'b0}}, cur_head_q};
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q  <= cmd_i.out_kind;
      drv_q   <= '0;
      cyl_q   <= '0;
      head_q  <= '0;
      first_q <= '0;
      count_q <= '0;
      slot_q  <= '0;
      case (cmd_i.out_kind)
        sctc_pkg::KIND_TRACK: begin
          drv_q   <= drive_q;
          cyl_q   <= cur_cyl_q;
          head_q  <= cur_head_q;
          first_q <= sctc_pkg::FIRST_W'(1);
          count_q <= spt_q[sctc_pkg::COUNT_W-1:0];
        end
        sctc_pkg::KIND_SECTOR: begin
          drv_q   <= drive_q;
          cyl_q   <= cur_cyl_q;
          head_q  <= cur_head_q;
          first_q <= {1'b0, cur_sec_q} + sctc_pkg::FIRST_W'(1);
          count_q <= sctc_pkg::COUNT_W'(1);
        end
        sctc_pkg::KIND_DONE: begin
          if (cmd_i.out_slot) begin
            slot_q <= cur_sec_q[sctc_pkg::SLOT_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign drive_o        = drv_q;
  assign cylinder_o     = cyl_q;
  assign head_o         = head_q;
  assign first_sector_o = first_q;
  assign sector_count_o = count_q;
  assign buffer_slot_o  = slot_q;

endmodule

// ===== sv/sctc_ctrl.sv =====
// Controller state machine: sequences translation, cache lookup, retries and result transfers.
// Depends on sctc_pkg; drives sctc_dp through command and status structs.
module sctc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 action_i,
  input  logic                 read_ok_i,
  input  sctc_pkg::sctc_stat_t stat_i,
  output sctc_pkg::sctc_cmd_t  cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_START  = 4'd1;
  localparam logic [3:0] ST_DIV1   = 4'd2;
  localparam logic [3:0] ST_DIV2S  = 4'd3;
  localparam logic [3:0] ST_DIV2   = 4'd4;
  localparam logic [3:0] ST_MUL    = 4'd5;
  localparam logic [3:0] ST_LT     = 4'd6;
  localparam logic [3:0] ST_DECIDE = 4'd7;
  localparam logic [3:0] ST_TRACK  = 4'd8;
  localparam logic [3:0] ST_SERVE  = 4'd9;
  localparam logic [3:0] ST_SSTAT  = 4'd10;
  localparam logic [3:0] ST_EMIT   = 4'd11;

  localparam logic [1:0] PEND_IDLE   = 2'd0;
  localparam logic [1:0] PEND_TRACK  = 2'd1;
  localparam logic [1:0] PEND_SECTOR = 2'd2;

  logic [3:0]                     state_q, state_d;
  logic [1:0]                     pend_q, pend_d;
  logic [sctc_pkg::TRIES_W-1:0]   tries_q, tries_d, tries_dec;
  logic                           req_q, req_d;
  logic                           ok_q, ok_d;
  logic [sctc_pkg::KIND_W-1:0]    kind_q, kind_d;
  logic                           slot_q, slot_d;
  logic                           accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign tries_dec  = (tries_q != '0) ? tries_q - 1'b1 : tries_q;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    tries_d = tries_q;
    req_d   = req_q;
    ok_d    = ok_q;
    kind_d  = kind_q;
    slot_d  = slot_q;
    cmd_o   = '0;
    cmd_o.out_kind = kind_q;
    cmd_o.out_slot = slot_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ok_d = read_ok_i;
          if (!action_i) begin
            cmd_o.load_req = 1'b1;
            req_d   = 1'b1;
            state_d = ST_START;
          end else if (pend_q == PEND_TRACK) begin
            req_d   = 1'b0;
            state_d = ST_MUL;
          end else if (pend_q == PEND_SECTOR) begin
            state_d = ST_SSTAT;
          end
        end
      end
      ST_START: begin
        if (stat_i.geo_zero) begin
          cmd_o.pass = 1'b1;
          state_d    = ST_MUL;
        end else begin
          cmd_o.div1_start = 1'b1;
          state_d          = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (stat_i.div_done) begin
          cmd_o.div1_store = 1'b1;
          state_d          = ST_DIV2S;
        end
      end
      ST_DIV2S: begin
        cmd_o.div2_start = 1'b1;
        state_d          = ST_DIV2;
      end
      ST_DIV2: begin
        if (stat_i.div_done) begin
          cmd_o.div2_store = 1'b1;
          state_d          = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_LT;
      end
      ST_LT: begin
        cmd_o.lt = 1'b1;
        state_d  = req_q ? ST_DECIDE : ST_TRACK;
      end
      ST_DECIDE: begin
        if (stat_i.track_cond) begin
          pend_d  = PEND_TRACK;
          kind_d  = sctc_pkg::KIND_TRACK;
          slot_d  = 1'b0;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_SERVE;
        end
      end
      ST_TRACK: begin
        cmd_o.cache_set = ok_q;
        cmd_o.bad_set   = !ok_q;
        state_d         = ST_SERVE;
      end
      ST_SERVE: begin
        if (stat_i.hit) begin
          pend_d = PEND_IDLE;
          kind_d = sctc_pkg::KIND_DONE;
          slot_d = 1'b1;
        end else begin
          tries_d         = sctc_pkg::READ_TRIES;
          cmd_o.cache_clr = 1'b1;
          pend_d          = PEND_SECTOR;
          kind_d          = sctc_pkg::KIND_SECTOR;
          slot_d          = 1'b0;
        end
        state_d = ST_EMIT;
      end
      ST_SSTAT: begin
        tries_d = tries_dec;
        slot_d  = 1'b0;
        if (ok_q) begin
          pend_d = PEND_IDLE;
          kind_d = sctc_pkg::KIND_DONE;
        end else if (tries_dec != '0) begin
          cmd_o.cache_clr = 1'b1;
          pend_d          = PEND_SECTOR;
          kind_d          = sctc_pkg::KIND_SECTOR;
        end else begin
          pend_d = PEND_IDLE;
          kind_d = sctc_pkg::KIND_FAIL;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= PEND_IDLE;
      tries_q <= sctc_pkg::READ_TRIES;
      req_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      tries_q <= tries_d;
      req_q   <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q   <= ok_d;
    kind_q <= kind_d;
    slot_q <= slot_d;
  end

`ifndef SYNTHESIS
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("result loaded while the output register is still occupied");

  a_tries_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tries_q <= sctc_pkg::READ_TRIES)
    else $error("retry counter above its limit");

  a_sector_pending_has_tries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == PEND_SECTOR) |-> (tries_q != '0))
    else $error("sector read outstanding with no tries left");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.div_done |-> ((state_q == ST_DIV1) || (state_q == ST_DIV2)))
    else $error("divider finished outside a divide state");
`endif

endmodule
